// ===== hw/rtl/fqm_pkg.sv =====
// ----------------------------------------------------------------------------
// fqm_pkg
// Shared constants, request codes and unit request types for the flow QoS
// metrics tracker.
// ----------------------------------------------------------------------------
package fqm_pkg;

  localparam int FLOW_COUNT = 256;
  localparam int FLOW_BITS  = 8;
  localparam int COUNT_BITS = 20;
  localparam int TIME_BITS  = 20;
  localparam int SUM_BITS   = 40;
  localparam int SQ_BITS    = 60;
  localparam int MUL_W      = 64;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CHUNK_W    = 16;
  localparam int CHUNKS     = MUL_W / CHUNK_W;
  localparam int NUM_W      = 80;
  localparam int DIV_CNT_W  = 7;

  localparam logic [2:0] REQ_SENT    = 3'd0;
  localparam logic [2:0] REQ_DROP    = 3'd1;
  localparam logic [2:0] REQ_DELIVER = 3'd2;
  localparam logic [2:0] REQ_WINDOW  = 3'd3;
  localparam logic [2:0] REQ_QUEUE   = 3'd4;

  localparam logic [1:0] CFG_DELAY_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_JITTER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_LOSS_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_WINDOW_LEN   = 2'd3;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [MUL_W-1:0] den;
    logic [MUL_W-1:0] lim;
  } div_req_t;

endpackage

// ===== hw/rtl/fqm_mul.sv =====
// ----------------------------------------------------------------------------
// fqm_mul
// Shared multiplier: 64 x 64 product, one 16-bit chunk of b per cycle.
// ----------------------------------------------------------------------------
module fqm_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  fqm_pkg::mul_req_t         req,
  output logic                      done,
  output logic [fqm_pkg::PROD_W-1:0] prod
);

  logic [fqm_pkg::MUL_W-1:0]  a_reg;
  logic [fqm_pkg::MUL_W-1:0]  b_sh;
  logic [2:0]                 cnt;
  logic                       running;
  logic [fqm_pkg::MUL_W+fqm_pkg::CHUNK_W-1:0] part;

  // msb chunk first, accumulator shifts up each step
  assign part = a_reg * b_sh[fqm_pkg::MUL_W-1 -: fqm_pkg::CHUNK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 3'(fqm_pkg::CHUNKS);
      end else if (running) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_sh  <= req.b;
      prod  <= '0;
    end else if (running) begin
      b_sh <= b_sh << fqm_pkg::CHUNK_W;
      prod <= (prod << fqm_pkg::CHUNK_W)
              + {{(fqm_pkg::PROD_W-fqm_pkg::MUL_W-fqm_pkg::CHUNK_W){1'b0}}, part};
    end
  end

endmodule

// ===== hw/rtl/fqm_div.sv =====
// ----------------------------------------------------------------------------
// fqm_div
// Shared radix-2 restoring divider, 80-bit dividend, saturating quotient.
// ----------------------------------------------------------------------------
module fqm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  fqm_pkg::div_req_t        req,
  output logic                     done,
  output logic [fqm_pkg::MUL_W-1:0] quo
);

  logic [fqm_pkg::NUM_W-1:0]     num_sh;
  logic [fqm_pkg::NUM_W-1:0]     q;
  logic [fqm_pkg::MUL_W-1:0]     rem;
  logic [fqm_pkg::MUL_W-1:0]     den;
  logic [fqm_pkg::MUL_W-1:0]     lim;
  logic [fqm_pkg::DIV_CNT_W-1:0] cnt;
  logic                          running;
  logic [fqm_pkg::MUL_W:0]       sh;
  logic                          fits;

  assign sh   = {rem, num_sh[fqm_pkg::NUM_W-1]};
  assign fits = sh >= {1'b0, den};

  // saturate the finished quotient to the requested maximum
  assign quo = (q > {{(fqm_pkg::NUM_W-fqm_pkg::MUL_W){1'b0}}, lim})
               ? lim : q[fqm_pkg::MUL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= fqm_pkg::DIV_CNT_W'(fqm_pkg::NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == fqm_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den    <= req.den;
      lim    <= req.lim;
      rem    <= '0;
      q      <= '0;
    end else if (running) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? fqm_pkg::MUL_W'(sh - {1'b0, den}) : sh[fqm_pkg::MUL_W-1:0];
      q      <= {q[fqm_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/flow_qos_metrics_tracker.sv =====
// ----------------------------------------------------------------------------
// flow_qos_metrics_tracker
// Window QoS statistics over packet events with a per-flow last-delay table.
// ----------------------------------------------------------------------------
// sequence: each accepted word runs a table read and an update step plus eight
//   multiplies and five divides one after another on the shared units; a divide
//   is skipped for an empty count or a zero window, and the variance divide also
//   for fewer than two deliveries or a numerator that is not positive
// overlap: none; a new word is taken only after the result word is handed off
// reset: rst clears totals, limits to their defaults and all table valid bits
module flow_qos_metrics_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [7:0]  flow_id,
  input  logic [15:0] packet_bytes,
  input  logic [19:0] rtt_us,
  input  logic [19:0] delay_us,
  input  logic [15:0] queue_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] mean_rtt_us,
  output logic [39:0] rtt_variance,
  output logic [19:0] mean_jitter_us,
  output logic [15:0] loss_frac,
  output logic [62:0] throughput_bps,
  output logic [15:0] queue_now,
  output logic        degraded
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [3:0] ST_SQ   = 4'd0;
  localparam logic [3:0] ST_UPD  = 4'd1;
  localparam logic [3:0] ST_VA   = 4'd2;
  localparam logic [3:0] ST_VB   = 4'd3;
  localparam logic [3:0] ST_VC   = 4'd4;
  localparam logic [3:0] ST_VD   = 4'd5;
  localparam logic [3:0] ST_MR   = 4'd6;
  localparam logic [3:0] ST_MJ   = 4'd7;
  localparam logic [3:0] ST_LS   = 4'd8;
  localparam logic [3:0] ST_TB   = 4'd9;
  localparam logic [3:0] ST_TP   = 4'd10;
  localparam logic [3:0] ST_CR   = 4'd11;
  localparam logic [3:0] ST_CJ   = 4'd12;
  localparam logic [3:0] ST_CL   = 4'd13;

  localparam int CB = fqm_pkg::COUNT_BITS;
  localparam int TB = fqm_pkg::TIME_BITS;
  localparam int SB = fqm_pkg::SUM_BITS;
  localparam int QB = fqm_pkg::SQ_BITS;
  localparam int MW = fqm_pkg::MUL_W;
  localparam int NW = fqm_pkg::NUM_W;

  localparam logic [MW-1:0] LIM_MEAN = MW'((64'd1 << TB) - 64'd1);
  localparam logic [MW-1:0] LIM_VAR  = MW'((64'd1 << 40) - 64'd1);
  localparam logic [MW-1:0] LIM_LOSS = MW'(16'hFFFF);
  localparam logic [MW-1:0] LIM_TPUT = MW'((64'd1 << 63) - 64'd1);
  localparam logic [MW-1:0] BPS_SCALE = MW'(8000000);

  logic [2:0]  state;
  logic [3:0]  step;

  logic [19:0] delay_limit;
  logic [19:0] jitter_limit;
  logic [15:0] loss_limit;
  logic [31:0] window_len;

  logic [2:0]    typ;
  logic [fqm_pkg::FLOW_BITS-1:0] flow;
  logic [15:0]   bytes;
  logic [TB-1:0] rtt;
  logic [TB-1:0] dly;
  logic [15:0]   qlev;

  logic [TB-1:0] last_mem [fqm_pkg::FLOW_COUNT];
  logic [fqm_pkg::FLOW_COUNT-1:0] last_vld;
  logic [TB-1:0] last_raw;
  logic          last_ok;

  logic [CB-1:0] sent_total, drop_total, delivered_total, jitter_total;
  logic [SB-1:0] byte_sum, rtt_sum, jitter_sum;
  logic [QB-1:0] rtt_square_sum;
  logic [15:0]   queue_held;

  logic [NW-1:0] prod_a, prod_b;
  logic [39:0]   prod_c;
  logic [MW-1:0] prod_d;
  logic [39:0]   rtt_sq;
  logic          deg_rtt, deg_jit, deg_loss;

  fqm_pkg::mul_req_t mul_req;
  fqm_pkg::div_req_t div_req;
  logic                        mul_done, div_done;
  logic [fqm_pkg::PROD_W-1:0]  prod;
  logic [MW-1:0]               quo;

  logic          is_mul, skip, unit_done;
  logic [TB-1:0] last_eff, jit_diff;
  logic [CB-1:0] cnt_max;
  logic [SB:0]   byte_add, rtt_add, jit_add;
  logic [QB:0]   sq_add;
  logic [CB-1:0] n_minus;
  logic [35:0]   drop_sh;
  logic          n_ge2;

  fqm_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .prod(prod));
  fqm_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(quo));

  assign cnt_max  = '1;
  assign last_eff = last_ok ? last_raw : '0;
  assign jit_diff = (dly > last_eff) ? dly - last_eff : last_eff - dly;
  assign byte_add = {1'b0, byte_sum} + (SB+1)'(bytes);
  assign rtt_add  = {1'b0, rtt_sum} + (SB+1)'(rtt);
  assign jit_add  = {1'b0, jitter_sum} + (SB+1)'(jit_diff);
  assign sq_add   = {1'b0, rtt_square_sum} + (QB+1)'(rtt_sq);
  assign n_minus  = delivered_total - 1'b1;
  assign n_ge2    = delivered_total > CB'(1);
  assign drop_sh  = {drop_total, 16'h0};

  always_comb begin
    case (step)
      ST_SQ, ST_VA, ST_VB, ST_VC, ST_TB, ST_CR, ST_CJ, ST_CL: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    case (step)
      ST_UPD:  skip = 1'b1;
      ST_VD:   skip = !n_ge2 || (prod_a <= prod_b);
      ST_MR:   skip = delivered_total == '0;
      ST_MJ:   skip = jitter_total == '0;
      ST_LS:   skip = sent_total == '0;
      ST_TP:   skip = window_len == '0;
      default: skip = 1'b0;
    endcase
  end

  assign unit_done = is_mul ? mul_done : div_done;

  // operand selection for the shared units
  always_comb begin
    mul_req       = '0;
    div_req       = '0;
    mul_req.start = (state == S_ISSUE) && is_mul;
    div_req.start = (state == S_ISSUE) && !is_mul && !skip;
    case (step)
      ST_SQ: begin
        mul_req.a = MW'(rtt);
        mul_req.b = MW'(rtt);
      end
      ST_VA: begin
        mul_req.a = MW'(delivered_total);
        mul_req.b = MW'(rtt_square_sum);
      end
      ST_VB: begin
        mul_req.a = MW'(rtt_sum);
        mul_req.b = MW'(rtt_sum);
      end
      ST_VC: begin
        mul_req.a = MW'(delivered_total);
        mul_req.b = MW'(n_minus);
      end
      ST_VD: begin
        div_req.num = prod_a - prod_b;
        div_req.den = MW'(prod_c);
        div_req.lim = LIM_VAR;
      end
      ST_MR: begin
        div_req.num = NW'(rtt_sum);
        div_req.den = MW'(delivered_total);
        div_req.lim = LIM_MEAN;
      end
      ST_MJ: begin
        div_req.num = NW'(jitter_sum);
        div_req.den = MW'(jitter_total);
        div_req.lim = LIM_MEAN;
      end
      ST_LS: begin
        div_req.num = NW'(drop_sh);
        div_req.den = MW'(sent_total);
        div_req.lim = LIM_LOSS;
      end
      ST_TB: begin
        mul_req.a = MW'(byte_sum);
        mul_req.b = BPS_SCALE;
      end
      ST_TP: begin
        div_req.num = NW'(prod_d);
        div_req.den = MW'(window_len);
        div_req.lim = LIM_TPUT;
      end
      ST_CR: begin
        mul_req.a = MW'(delay_limit);
        mul_req.b = MW'(delivered_total);
      end
      ST_CJ: begin
        mul_req.a = MW'(jitter_limit);
        mul_req.b = MW'(jitter_total);
      end
      ST_CL: begin
        mul_req.a = MW'(loss_limit);
        mul_req.b = MW'(sent_total);
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign queue_now = queue_held;
  assign degraded  = deg_rtt || deg_jit || deg_loss;

  // last-delay table, registered read at accept
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      last_raw <= last_mem[flow_id];
    end
    if (state == S_ISSUE && step == ST_UPD && typ == fqm_pkg::REQ_DELIVER) begin
      last_mem[flow] <= dly;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= ST_SQ;
      delay_limit     <= 20'd100000;
      jitter_limit    <= 20'd10000;
      loss_limit      <= 16'd655;
      window_len      <= 32'd1000000;
      last_vld        <= '0;
      sent_total      <= '0;
      drop_total      <= '0;
      delivered_total <= '0;
      jitter_total    <= '0;
      byte_sum        <= '0;
      rtt_sum         <= '0;
      rtt_square_sum  <= '0;
      jitter_sum      <= '0;
      queue_held      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fqm_pkg::CFG_DELAY_LIMIT:  delay_limit  <= cfg_data[19:0];
          fqm_pkg::CFG_JITTER_LIMIT: jitter_limit <= cfg_data[19:0];
          fqm_pkg::CFG_LOSS_LIMIT:   loss_limit   <= cfg_data[15:0];
          fqm_pkg::CFG_WINDOW_LEN:   window_len   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_ok <= last_vld[flow_id];
            state   <= S_READ;
          end
        end
        S_READ: begin
          step  <= ST_SQ;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (step == ST_UPD) begin
            case (typ)
              fqm_pkg::REQ_SENT: begin
                if (sent_total != cnt_max) sent_total <= sent_total + 1'b1;
              end
              fqm_pkg::REQ_DROP: begin
                if (drop_total != cnt_max) drop_total <= drop_total + 1'b1;
              end
              fqm_pkg::REQ_DELIVER: begin
                if (delivered_total != cnt_max) delivered_total <= delivered_total + 1'b1;
                byte_sum       <= byte_add[SB] ? '1 : byte_add[SB-1:0];
                rtt_sum        <= rtt_add[SB] ? '1 : rtt_add[SB-1:0];
                rtt_square_sum <= sq_add[QB] ? '1 : sq_add[QB-1:0];
                if (last_eff != '0) begin
                  jitter_sum <= jit_add[SB] ? '1 : jit_add[SB-1:0];
                  if (jitter_total != cnt_max) jitter_total <= jitter_total + 1'b1;
                end
                last_vld[flow] <= 1'b1;
              end
              fqm_pkg::REQ_WINDOW: begin
                sent_total      <= '0;
                drop_total      <= '0;
                delivered_total <= '0;
                jitter_total    <= '0;
                byte_sum        <= '0;
                rtt_sum         <= '0;
                rtt_square_sum  <= '0;
                jitter_sum      <= '0;
              end
              fqm_pkg::REQ_QUEUE: queue_held <= qlev;
              default: ;
            endcase
          end
          if (skip) begin
            if (step == ST_CL) state <= S_OUT;
            else step <= step + 4'd1;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            if (step == ST_CL) begin
              state <= S_OUT;
            end else begin
              step  <= step + 4'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input capture and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      typ   <= req_type;
      flow  <= flow_id;
      bytes <= packet_bytes;
      rtt   <= rtt_us;
      dly   <= delay_us;
      qlev  <= queue_level;
    end
    if (state == S_ISSUE && skip) begin
      case (step)
        ST_VD:   rtt_variance   <= '0;
        ST_MR:   mean_rtt_us    <= '0;
        ST_MJ:   mean_jitter_us <= '0;
        ST_LS:   loss_frac      <= '0;
        ST_TP:   throughput_bps <= '0;
        default: ;
      endcase
    end
    if (state == S_WAIT && unit_done) begin
      case (step)
        ST_SQ:   rtt_sq         <= prod[39:0];
        ST_VA:   prod_a         <= prod[NW-1:0];
        ST_VB:   prod_b         <= prod[NW-1:0];
        ST_VC:   prod_c         <= prod[39:0];
        ST_VD:   rtt_variance   <= quo[39:0];
        ST_MR:   mean_rtt_us    <= quo[19:0];
        ST_MJ:   mean_jitter_us <= quo[19:0];
        ST_LS:   loss_frac      <= quo[15:0];
        ST_TB:   prod_d         <= prod[MW-1:0];
        ST_TP:   throughput_bps <= quo[62:0];
        ST_CR:   deg_rtt  <= (delivered_total != '0) && ({88'd0, rtt_sum} > prod);
        ST_CJ:   deg_jit  <= (jitter_total != '0) && ({88'd0, jitter_sum} > prod);
        ST_CL:   deg_loss <= (sent_total != '0) && ({92'd0, drop_sh} > prod);
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fqm_checker.sv =====
// ----------------------------------------------------------------------------
// fqm_checker
// Port-level checks for the flow QoS metrics tracker, bound to the top level.
// ----------------------------------------------------------------------------
module fqm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] mean_rtt_us,
  input logic        degraded
);

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  a_out_only_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result shown while input side is open");

  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated after handoff");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mean_rtt_us) && $stable(degraded)))
    else $error("stalled result changed");

endmodule

bind flow_qos_metrics_tracker fqm_checker u_fqm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .mean_rtt_us(mean_rtt_us), .degraded(degraded)
);

// ===== dv/flow_qos_metrics_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_qos_metrics_tracker_tb
// Self-checking bench: drives packet events with random gaps and output
// stalls, predicts each statistics word and compares it with the result word.
// ----------------------------------------------------------------------------
module flow_qos_metrics_tracker_tb;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [7:0]  flow_id;
  logic [15:0] packet_bytes;
  logic [19:0] rtt_us;
  logic [19:0] delay_us;
  logic [15:0] queue_level;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] mean_rtt_us;
  logic [39:0] rtt_variance;
  logic [19:0] mean_jitter_us;
  logic [15:0] loss_frac;
  logic [62:0] throughput_bps;
  logic [15:0] queue_now;
  logic        degraded;

  flow_qos_metrics_tracker dut (.*);

  typedef struct packed {
    logic [19:0] mean_rtt;
    logic [39:0] variance;
    logic [19:0] mean_jitter;
    logic [15:0] loss;
    logic [62:0] tput;
    logic [15:0] queue;
    logic        deg;
  } stats_t;

  localparam logic [19:0] CNT_MAX = '1;
  localparam logic [39:0] S40_MAX = '1;
  localparam logic [59:0] S60_MAX = '1;

  // predictor state
  logic [19:0] lim_delay, lim_jitter;
  logic [15:0] lim_loss;
  logic [31:0] win_len;
  logic [19:0] prev_dly [fqm_pkg::FLOW_COUNT];
  logic [19:0] n_sent, n_drop, n_deliv, n_jit;
  logic [39:0] bytes_acc, rtt_acc, jit_acc;
  logic [59:0] rtt_sq_acc;
  logic [15:0] queue_q;

  stats_t stats_queue[$];
  int     errors;
  int     mismatches;
  bit     busy_tail;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL flow_qos_metrics_tracker");
    $finish;
  end

  function automatic logic [19:0] c_inc(logic [19:0] v);
    return (v == CNT_MAX) ? v : v + 20'd1;
  endfunction

  function automatic logic [39:0] s40_add(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? S40_MAX : s[39:0];
  endfunction

  function automatic logic [19:0] q20(logic [39:0] n, logic [19:0] d);
    logic [39:0] q;
    if (d == 0) return '0;
    q = n / d;
    return (q > 40'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  function automatic stats_t predict_stats(logic [2:0] rq, logic [7:0] fl, logic [15:0] by,
                                           logic [19:0] rt, logic [19:0] dl, logic [15:0] ql);
    stats_t r;
    logic [19:0] prev, dj;
    logic [60:0] sq;
    logic [127:0] num, vnum, vden, q;
    logic [35:0] lq;
    if (rq == fqm_pkg::REQ_SENT) n_sent = c_inc(n_sent);
    else if (rq == fqm_pkg::REQ_DROP) n_drop = c_inc(n_drop);
    else if (rq == fqm_pkg::REQ_DELIVER) begin
      n_deliv   = c_inc(n_deliv);
      bytes_acc = s40_add(bytes_acc, 40'(by));
      rtt_acc   = s40_add(rtt_acc, 40'(rt));
      sq = {1'b0, rtt_sq_acc} + 61'(rt) * 61'(rt);
      rtt_sq_acc = sq[60] ? S60_MAX : sq[59:0];
      prev = prev_dly[fl];
      if (prev != 0) begin
        dj = (dl > prev) ? dl - prev : prev - dl;
        jit_acc = s40_add(jit_acc, 40'(dj));
        n_jit   = c_inc(n_jit);
      end
      prev_dly[fl] = dl;
    end else if (rq == fqm_pkg::REQ_WINDOW) begin
      n_sent = 0; n_drop = 0; n_deliv = 0; n_jit = 0;
      bytes_acc = 0; rtt_acc = 0; rtt_sq_acc = 0; jit_acc = 0;
    end else if (rq == fqm_pkg::REQ_QUEUE) queue_q = ql;

    r.mean_rtt    = q20(rtt_acc, n_deliv);
    r.mean_jitter = q20(jit_acc, n_jit);
    if (n_sent == 0) r.loss = 0;
    else begin
      lq = {n_drop, 16'b0} / n_sent;
      r.loss = (lq > 36'hFFFF) ? 16'hFFFF : lq[15:0];
    end
    if (win_len == 0) r.tput = 0;
    else begin
      q = (128'(bytes_acc) * 128'd8000000) / win_len;
      r.tput = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? '1 : q[62:0];
    end
    r.variance = 0;
    if (n_deliv >= 2) begin
      num  = 128'(n_deliv) * 128'(rtt_sq_acc);
      vnum = 128'(rtt_acc) * 128'(rtt_acc);
      if (num > vnum) begin
        vden = 128'(n_deliv) * 128'(n_deliv - 20'd1);
        q = (num - vnum) / vden;
        r.variance = (q > 128'(S40_MAX)) ? S40_MAX : q[39:0];
      end
    end
    r.queue = queue_q;
    r.deg = (n_deliv != 0 && 64'(rtt_acc) > 64'(lim_delay) * 64'(n_deliv))
         || (n_jit != 0 && 64'(jit_acc) > 64'(lim_jitter) * 64'(n_jit))
         || (n_sent != 0 && 64'({n_drop, 16'b0}) > 64'(lim_loss) * 64'(n_sent));
    return r;
  endfunction

  // result checker with random output stalls
  always @(posedge clk) begin
    stats_t got, exp_s;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{mean_rtt_us, rtt_variance, mean_jitter_us, loss_frac, throughput_bps,
                queue_now, degraded};
        if (stats_queue.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result word %h", got);
        end else begin
          exp_s = stats_queue.pop_front();
          if (got !== exp_s) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp rtt=%0d var=%0d jit=%0d loss=%0d tput=%0d q=%0d deg=%0d"
                       , exp_s.mean_rtt, exp_s.variance, exp_s.mean_jitter, exp_s.loss,
                       exp_s.tput, exp_s.queue, exp_s.deg);
            if (mismatches <= 10)
              $display("          got rtt=%0d var=%0d jit=%0d loss=%0d tput=%0d q=%0d deg=%0d",
                       got.mean_rtt, got.variance, got.mean_jitter, got.loss, got.tput,
                       got.queue, got.deg);
          end
        end
      end
      if (busy_tail) out_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 10) out_stall <= ($urandom_range(0, 9) != 0);
    end
  end

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_event(logic [2:0] rq, logic [7:0] fl, logic [15:0] by,
                            logic [19:0] rt, logic [19:0] dl, logic [15:0] ql);
    stats_t e;
    gap();
    in_valid     <= 1'b1;
    req_type     <= rq;
    flow_id      <= fl;
    packet_bytes <= by;
    rtt_us       <= rt;
    delay_us     <= dl;
    queue_level  <= ql;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_stats(rq, fl, by, rt, dl, ql);
    stats_queue.insert(stats_queue.size(), e);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(logic [2:0] rq);
    send_event(rq, 8'($urandom), 16'($urandom), 20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    while (stats_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fqm_pkg::CFG_DELAY_LIMIT:  lim_delay  = val[19:0];
      fqm_pkg::CFG_JITTER_LIMIT: lim_jitter = val[19:0];
      fqm_pkg::CFG_LOSS_LIMIT:   lim_loss   = val[15:0];
      default:                   win_len    = val;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_event(fqm_pkg::REQ_SENT, 8'd0, '1, '1, '1, '1);
    send_event(fqm_pkg::REQ_SENT, 8'd0, 0, 0, 0, 0);
    send_event(fqm_pkg::REQ_DROP, 8'd3, 0, 0, 0, 0);
    send_event(fqm_pkg::REQ_QUEUE, 8'd0, 0, 0, 0, 16'hFFFF);
    send_event(fqm_pkg::REQ_QUEUE, 8'd0, 0, 0, 0, 16'h0000);
    send_event(fqm_pkg::REQ_DELIVER, 8'd0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 0);
    send_event(fqm_pkg::REQ_DELIVER, 8'd0, 16'd0, 20'd0, 20'd0, 0);
    send_event(fqm_pkg::REQ_DELIVER, 8'd0, 16'd100, 20'd50, 20'd10, 0);
    send_event(fqm_pkg::REQ_DELIVER, 8'd255, 16'd1500, 20'd200000, 20'd500, 0);
    send_event(fqm_pkg::REQ_DELIVER, 8'd255, 16'd1500, 20'd150000, 20'd30000, 0);
    send_event(fqm_pkg::REQ_DELIVER, 8'd0, 16'd64, 20'd1, 20'hFFFFF, 0);
    send_event(3'd5, 8'd1, '1, '1, '1, '1);
    send_event(3'd6, 8'd2, 0, 0, 0, 0);
    send_event(3'd7, 8'd3, 0, 0, 0, 0);
    send_event(fqm_pkg::REQ_DROP, 8'd0, 0, 0, 0, 0);
    send_event(fqm_pkg::REQ_WINDOW, 8'd0, 0, 0, 0, 0);
    // last delays survive the window clear
    send_event(fqm_pkg::REQ_DELIVER, 8'd255, 16'd10, 20'd10, 20'd40000, 0);
    send_event(fqm_pkg::REQ_DROP, 8'd0, 0, 0, 0, 0);
    drain();
  endtask

  // mostly well-formed traffic on flows 0 to flow_span, some noise
  task automatic test_random(int items, logic [7:0] flow_span);
    int k;
    logic [2:0] rq;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) rq = fqm_pkg::REQ_SENT;
      else if (k < 38) rq = fqm_pkg::REQ_DROP;
      else if (k < 85) rq = fqm_pkg::REQ_DELIVER;
      else if (k < 88) rq = fqm_pkg::REQ_WINDOW;
      else if (k < 96) rq = fqm_pkg::REQ_QUEUE;
      else rq = 3'($urandom_range(5, 7));
      if (rq == fqm_pkg::REQ_DELIVER && $urandom_range(0, 3) != 0)
        send_event(rq, 8'($urandom_range(0, flow_span)), 16'($urandom),
                   20'($urandom_range(0, 300000)), 20'($urandom_range(0, 60000)), 0);
      else send_random(rq);
    end
    drain();
  endtask

  task automatic test_config(logic [19:0] dl, logic [19:0] jl, logic [15:0] ll,
                             logic [31:0] wl);
    write_reg(fqm_pkg::CFG_DELAY_LIMIT, 32'(dl));
    write_reg(fqm_pkg::CFG_JITTER_LIMIT, 32'(jl));
    write_reg(fqm_pkg::CFG_LOSS_LIMIT, 32'(ll));
    write_reg(fqm_pkg::CFG_WINDOW_LEN, wl);
  endtask

  // deliveries of full-size packets, often with maximum rtt, on flows 0 to 3
  task automatic test_saturation();
    for (int i = 0; i < 40; i++)
      send_event(fqm_pkg::REQ_DELIVER, 8'($urandom_range(0, 3)), 16'hFFFF,
                 ($urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom)), 20'($urandom), 0);
    drain();
  endtask

  initial begin
    rst = 1; cfg_write = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; req_type = 0; flow_id = 0; packet_bytes = 0;
    rtt_us = 0; delay_us = 0; queue_level = 0;
    errors = 0; mismatches = 0; busy_tail = 0;
    lim_delay = 20'd100000; lim_jitter = 20'd10000; lim_loss = 16'd655; win_len = 32'd1000000;
    foreach (prev_dly[i]) prev_dly[i] = 0;
    n_sent = 0; n_drop = 0; n_deliv = 0; n_jit = 0;
    bytes_acc = 0; rtt_acc = 0; rtt_sq_acc = 0; jit_acc = 0; queue_q = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    test_random(300, 8'd7);
    test_config(20'd0, 20'd0, 16'd0, 32'd0);
    test_random(150, 8'd255);
    test_config(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    test_random(150, 8'd15);
    test_config(20'd120000, 20'd20000, 16'd8000, 32'd1);
    test_saturation();
    test_random(200, 8'd3);
    test_config(20'd150000, 20'd15000, 16'd20000, 32'd500000);
    test_random(200, 8'd31);

    busy_tail = 1;
    drain();
    if (errors == 0) $display("PASS flow_qos_metrics_tracker");
    else $display("FAIL flow_qos_metrics_tracker");
    $finish;
  end

endmodule
